@@ hdl/assert_macros.svh @@
// assertion macros used by the checker in ps2sc_checker.sv
// no dependencies; every macro samples on aclk and is disabled while aresetn is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PS2SC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ps2sc check failed");

// next-cycle implication
`define PS2SC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ps2sc check failed");

`endif

@@ hdl/ps2sc_pkg.sv @@
// shared constants, key kind codes and the set-1 character lookup
// no dependencies
`timescale 1ns / 1ps

package ps2sc_pkg;

    localparam int CODE_W = 24;
    localparam int KIND_W = 4;
    localparam int CHAR_W = 7;

    // key kind codes
    localparam logic [KIND_W-1:0] KIND_NONE   = 4'd0;
    localparam logic [KIND_W-1:0] KIND_CHAR   = 4'd1;
    localparam logic [KIND_W-1:0] KIND_ESC    = 4'd2;
    localparam logic [KIND_W-1:0] KIND_UP     = 4'd3;
    localparam logic [KIND_W-1:0] KIND_DOWN   = 4'd4;
    localparam logic [KIND_W-1:0] KIND_PGUP   = 4'd5;
    localparam logic [KIND_W-1:0] KIND_PGDOWN = 4'd6;
    localparam logic [KIND_W-1:0] KIND_HOME   = 4'd7;
    localparam logic [KIND_W-1:0] KIND_END    = 4'd8;

    // prefix bytes
    localparam logic [7:0] PREFIX_E0 = 8'hE0;
    localparam logic [7:0] PREFIX_E1 = 8'hE1;

    // codes with a meaning of their own
    localparam logic [CODE_W-1:0] CODE_ESC       = 24'h000001;
    localparam logic [CODE_W-1:0] CODE_LSHIFT_MK = 24'h00002A;
    localparam logic [CODE_W-1:0] CODE_RSHIFT_MK = 24'h000036;
    localparam logic [CODE_W-1:0] CODE_LSHIFT_BK = 24'h0000AA;
    localparam logic [CODE_W-1:0] CODE_RSHIFT_BK = 24'h0000B6;
    localparam logic [CODE_W-1:0] CODE_UP        = 24'h00E048;
    localparam logic [CODE_W-1:0] CODE_DOWN      = 24'h00E050;
    localparam logic [CODE_W-1:0] CODE_PGUP      = 24'h00E049;
    localparam logic [CODE_W-1:0] CODE_PGDOWN    = 24'h00E051;
    localparam logic [CODE_W-1:0] CODE_HOME      = 24'h00E047;
    localparam logic [CODE_W-1:0] CODE_END       = 24'h00E04F;

    // codes below this have a table entry
    localparam logic [CODE_W-1:0] TABLE_SIZE = 24'h00003A;

    // german layout character for a set-1 make code, 0 when there is none
    function automatic logic [CHAR_W-1:0] char_lookup(input logic [5:0] idx,
                                                      input logic       shifted);
        logic [CHAR_W-1:0] plain;
        logic [CHAR_W-1:0] digit_sh;
        plain    = 7'h00;
        digit_sh = 7'h00;
        unique case (idx)
            6'h02: begin plain = 7'h31; digit_sh = 7'h21; end
            6'h03: begin plain = 7'h32; digit_sh = 7'h22; end
            6'h04: begin plain = 7'h33; digit_sh = 7'h33; end
            6'h05: begin plain = 7'h34; digit_sh = 7'h24; end
            6'h06: begin plain = 7'h35; digit_sh = 7'h25; end
            6'h07: begin plain = 7'h36; digit_sh = 7'h26; end
            6'h08: begin plain = 7'h37; digit_sh = 7'h2F; end
            6'h09: begin plain = 7'h38; digit_sh = 7'h28; end
            6'h0A: begin plain = 7'h39; digit_sh = 7'h29; end
            6'h0B: begin plain = 7'h30; digit_sh = 7'h3D; end
            6'h10: plain = 7'h71;
            6'h11: plain = 7'h77;
            6'h12: plain = 7'h65;
            6'h13: plain = 7'h72;
            6'h14: plain = 7'h74;
            6'h15: plain = 7'h7A;
            6'h16: plain = 7'h75;
            6'h17: plain = 7'h69;
            6'h18: plain = 7'h6F;
            6'h19: plain = 7'h70;
            6'h1C: plain = 7'h0A;
            6'h1E: plain = 7'h61;
            6'h1F: plain = 7'h73;
            6'h20: plain = 7'h64;
            6'h21: plain = 7'h66;
            6'h22: plain = 7'h67;
            6'h23: plain = 7'h68;
            6'h24: plain = 7'h6A;
            6'h25: plain = 7'h6B;
            6'h26: plain = 7'h6C;
            6'h2C: plain = 7'h79;
            6'h2D: plain = 7'h78;
            6'h2E: plain = 7'h63;
            6'h2F: plain = 7'h76;
            6'h30: plain = 7'h62;
            6'h31: plain = 7'h6E;
            6'h32: plain = 7'h6D;
            6'h39: plain = 7'h20;
            default: plain = 7'h00;
        endcase
        if (!shifted) begin
            return plain;
        end else if (digit_sh != 7'h00) begin
            return digit_sh;
        end else if (plain >= 7'h61 && plain <= 7'h7A) begin
            // lower to upper case
            return plain ^ 7'h20;
        end else begin
            return plain;
        end
    endfunction

endpackage

@@ hdl/ps2sc_assembler.sv @@
// prefix tracker: joins E0 and E1 sequences into one scan code
// depends on ps2sc_pkg
`timescale 1ns / 1ps

module ps2sc_assembler
    import ps2sc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic [7:0]        rx_byte,
    output logic [CODE_W-1:0] scan_code
);

    // prefix phase codes
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_E0     = 2'd1;
    localparam logic [1:0] PH_E1     = 2'd2;
    localparam logic [1:0] PH_E1_MID = 2'd3;

    logic [1:0] phase_reg, phase_next;
    logic [7:0] ext_byte_reg, ext_byte_next;

    // next phase and assembled code
    always_comb begin
        phase_next    = phase_reg;
        ext_byte_next = ext_byte_reg;
        scan_code     = '0;
        unique case (phase_reg)
            PH_E0: begin
                scan_code  = {8'h00, PREFIX_E0, rx_byte};
                phase_next = PH_IDLE;
            end
            PH_E1: begin
                ext_byte_next = rx_byte;
                phase_next    = PH_E1_MID;
            end
            PH_E1_MID: begin
                scan_code  = {PREFIX_E1, ext_byte_reg, rx_byte};
                phase_next = PH_IDLE;
            end
            default: begin
                if (rx_byte == PREFIX_E0) begin
                    phase_next = PH_E0;
                end else if (rx_byte == PREFIX_E1) begin
                    phase_next = PH_E1;
                end else begin
                    scan_code = {16'h0000, rx_byte};
                end
            end
        endcase
    end

    // state moves only when a beat passes to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            ext_byte_reg <= 8'h00;
        end else if (advance) begin
            phase_reg    <= phase_next;
            ext_byte_reg <= ext_byte_next;
        end
    end

endmodule

@@ hdl/ps2sc_translate.sv @@
// translation of an assembled scan code and the shift-held flag
// depends on ps2sc_pkg
`timescale 1ns / 1ps

module ps2sc_translate
    import ps2sc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic [CODE_W-1:0] scan_code,
    output logic [KIND_W-1:0] key_kind,
    output logic [CHAR_W-1:0] char_code
);

    logic              shift_reg;
    logic [CHAR_W-1:0] lookup;

    assign lookup = char_lookup(scan_code[5:0], shift_reg);

    // key kind and character
    always_comb begin
        key_kind  = KIND_NONE;
        char_code = '0;
        unique case (scan_code)
            CODE_ESC:    key_kind = KIND_ESC;
            CODE_UP:     key_kind = KIND_UP;
            CODE_DOWN:   key_kind = KIND_DOWN;
            CODE_PGUP:   key_kind = KIND_PGUP;
            CODE_PGDOWN: key_kind = KIND_PGDOWN;
            CODE_HOME:   key_kind = KIND_HOME;
            CODE_END:    key_kind = KIND_END;
            default: begin
                // shift make codes have no table entry, break codes lie above it
                if (scan_code < TABLE_SIZE && lookup != '0) begin
                    key_kind  = KIND_CHAR;
                    char_code = lookup;
                end
            end
        endcase
    end

    // shift-held flag, only plain shift codes count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= 1'b0;
        end else if (advance) begin
            if (scan_code == CODE_LSHIFT_MK || scan_code == CODE_RSHIFT_MK) begin
                shift_reg <= 1'b1;
            end else if (scan_code == CODE_LSHIFT_BK || scan_code == CODE_RSHIFT_BK) begin
                shift_reg <= 1'b0;
            end
        end
    end

endmodule

@@ hdl/ps2_scancode_to_ascii_decoder.sv @@
// ps2 set-1 scan code decoder: input register, assembler, translator, result register
// path: an accepted input beat is held in the input register, then in the result register, which drives m_valid
// throughput: one beat per cycle while m_ready is high, set by the input and result registers alone
// reset: synchronous active-low aresetn empties both registers and clears prefix and shift
// depends on ps2sc_pkg, ps2sc_assembler, ps2sc_translate
`timescale 1ns / 1ps

module ps2_scancode_to_ascii_decoder
    import ps2sc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_rx_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CODE_W-1:0] m_scan_code,
    output logic [KIND_W-1:0] m_key_kind,
    output logic [CHAR_W-1:0] m_char_code
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg;
    logic [CODE_W-1:0] scan_code_reg, scan_code_next;
    logic [KIND_W-1:0] key_kind_reg, key_kind_next;
    logic [CHAR_W-1:0] char_code_reg, char_code_next;
    logic              advance;

    // beat moves to the result register when that register is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    ps2sc_assembler u_assembler (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .rx_byte   (in_byte_reg),
        .scan_code (scan_code_next)
    );

    ps2sc_translate u_translate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .scan_code (scan_code_next),
        .key_kind  (key_kind_next),
        .char_code (char_code_next)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            scan_code_reg <= scan_code_next;
            key_kind_reg  <= key_kind_next;
            char_code_reg <= char_code_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_scan_code = scan_code_reg;
    assign m_key_kind  = key_kind_reg;
    assign m_char_code = char_code_reg;

endmodule

@@ hdl/ps2sc_checker.sv @@
// port-level checks on the decoder's result channel, bound to the top level
// depends on ps2sc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ps2sc_checker
    import ps2sc_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [CODE_W-1:0] m_scan_code,
    input logic [KIND_W-1:0] m_key_kind,
    input logic [CHAR_W-1:0] m_char_code
);

    // a stalled result beat holds its payload
    `PS2SC_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_scan_code) && $stable(m_key_kind) && $stable(m_char_code))

    // a character is given exactly when the kind says so
    `PS2SC_ASSERT_IMPL(a_char_kind, m_valid, (m_key_kind == KIND_CHAR) == (m_char_code != '0))

    // prefix steps translate to nothing
    `PS2SC_ASSERT_IMPL(a_prefix_none, m_valid && m_scan_code == '0, m_key_kind == KIND_NONE)

    // a three-byte code always starts with E1
    `PS2SC_ASSERT_IMPL(a_top_e1, m_valid && m_scan_code[23:16] != 8'h00, m_scan_code[23:16] == PREFIX_E1)

    // a two-byte code always starts with E0
    `PS2SC_ASSERT_IMPL(a_mid_e0, m_valid && m_scan_code[23:16] == 8'h00 && m_scan_code[15:8] != 8'h00, m_scan_code[15:8] == PREFIX_E0)

endmodule

bind ps2_scancode_to_ascii_decoder ps2sc_checker u_ps2sc_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_scan_code (m_scan_code),
    .m_key_kind  (m_key_kind),
    .m_char_code (m_char_code)
);
